// File: hw/rtl/stsal_pkg.sv
// Shared types and codes for the symbol table sort and address lookup block.
package stsal_pkg;

	localparam int VALUE_W = 64;
	localparam int NAME_W  = 32;
	localparam int TYPE_W  = 6;
	localparam int SCOPE_W = 4;
	localparam int KEPT_W  = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	localparam logic [1:0] KIND_LOAD   = 2'd0;
	localparam logic [1:0] KIND_SORT   = 2'd1;
	localparam logic [1:0] KIND_LOOKUP = 2'd2;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_DROPPED  = 2'd1;
	localparam logic [1:0] STATUS_FULL     = 2'd2;
	localparam logic [1:0] STATUS_NOTFOUND = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_CODE_TYPE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_TYPE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GLOBAL     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNIVERSAL  = 2'd3;

	localparam logic [TYPE_W-1:0]  RST_CODE_TYPE  = 6'd3;
	localparam logic [TYPE_W-1:0]  RST_ENTRY_TYPE = 6'd6;
	localparam logic [SCOPE_W-1:0] RST_GLOBAL     = 4'd2;
	localparam logic [SCOPE_W-1:0] RST_UNIVERSAL  = 4'd3;

	localparam logic [VALUE_W-1:0] LOW_BITS_CLEAR = ~64'd3;

	typedef struct packed {
		logic [TYPE_W-1:0]  code_type;
		logic [TYPE_W-1:0]  entry_type;
		logic [SCOPE_W-1:0] global_scope;
		logic [SCOPE_W-1:0] universal_scope;
	} cfg_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [NAME_W-1:0]  name;
	} entry_t;

endpackage

// File: hw/rtl/stsal_filter.sv
// Keep filter that decides whether a loaded symbol enters the table.
module stsal_filter
	import stsal_pkg::*;
(
	input  cfg_t               cfg,
	input  logic [TYPE_W-1:0]  sym_type,
	input  logic [SCOPE_W-1:0] sym_scope,
	output logic               keep
);

	logic is_uni;
	logic is_glob;

	assign is_uni  = (sym_scope == cfg.universal_scope);
	assign is_glob = (sym_scope == cfg.global_scope);

	assign keep = ((sym_type == cfg.code_type) && is_uni) ||
		((sym_type == cfg.entry_type) && (is_uni || is_glob));

endmodule

// File: hw/rtl/symbol_table_sort_and_address_lookup_top.sv
// Top level of the symbol table: filtered load, in-place sort and address lookup.
//
// A request is taken at a clock edge where start is high and busy is low. Its
// kind selects a load, a sort or a lookup. Exactly one result follows, shown
// for one cycle with done high; the receiver cannot stall it.
// A load's result appears in the cycle after the request,
// and busy stays low, so loads can follow each other in every cycle.
// A sort is a selection sort over the table memory: each position scans the
// remaining entries with one read per cycle, waits for the last read, then writes
// the old entry into the minimum's slot and the minimum, low bits cleared, in its place.
// A lookup walks the memory from entry zero, one read per cycle. Both are
// bounded by the single read port of the memory.
// Registers are written through cfg_we, cfg_idx and cfg_wdata, by the user
// only while idle; the block does not enforce it. Reset clears the count and
// presets the registers; memory needs no clearing: only entries below the count are read.
module symbol_table_sort_and_address_lookup_top
	import stsal_pkg::*;
#(
	parameter int MAX_SYMBOLS = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            kind,
	input  logic [VALUE_W-1:0]    sym_value,
	input  logic [TYPE_W-1:0]     sym_type,
	input  logic [SCOPE_W-1:0]    sym_scope,
	input  logic [NAME_W-1:0]     name_ref,
	input  logic [VALUE_W-1:0]    lookup_addr,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output logic                  done,
	output logic [1:0]            status,
	output logic [NAME_W-1:0]     found_name_ref,
	output logic [VALUE_W-1:0]    found_offset,
	output logic [KEPT_W-1:0]     kept_count
);

	localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
	localparam int IDX_W = $clog2(MAX_SYMBOLS);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_WRM  = 3'd2;
	localparam logic [2:0] ST_WRI  = 3'd3;
	localparam logic [2:0] ST_LOOK = 3'd4;

	logic [2:0]         state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   ptr_q;
	logic [IDX_W-1:0]   i_q;
	logic [IDX_W-1:0]   m_q;
	entry_t             min_q;
	entry_t             ent_i_q;
	entry_t             prev_q;
	logic [VALUE_W-1:0] addr_q;
	cfg_t               cfg_q;
	logic               done_q;
	logic [1:0]         status_q;
	logic [NAME_W-1:0]  name_q;
	logic [VALUE_W-1:0] off_q;

	entry_t             mem [MAX_SYMBOLS];
	entry_t             rdata_s1;
	logic               rvld_s1;
	logic [IDX_W-1:0]   ridx_s1;

	logic               accept;
	logic               keep;
	logic               full;
	logic               rd_en;
	logic [IDX_W-1:0]   raddr;
	logic               we;
	logic [IDX_W-1:0]   waddr;
	entry_t             wdata;
	logic               last;
	logic               lk_found;
	logic               lk_miss;
	logic [CNT_W-1:0]   i_next;
	logic [CNT_W+KEPT_W-1:0] cnt_ext;

	stsal_filter u_filter (
		.cfg       (cfg_q),
		.sym_type  (sym_type),
		.sym_scope (sym_scope),
		.keep      (keep)
	);

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign full   = (cnt_q == CNT_W'(MAX_SYMBOLS));
	assign i_next = CNT_W'(i_q) + 1'b1;
	assign last   = (CNT_W'(ridx_s1) == (cnt_q - 1'b1));

	assign lk_found = (ridx_s1 != '0) && (addr_q < rdata_s1.value);
	assign lk_miss  = !lk_found &&
		((addr_q < rdata_s1.value) || (rdata_s1.value == '0) || last);

	assign rd_en = ((state_q == ST_SCAN) || (state_q == ST_LOOK)) && (ptr_q < cnt_q);
	assign raddr = ptr_q[IDX_W-1:0];

	always_comb begin
		we    = 1'b0;
		waddr = cnt_q[IDX_W-1:0];
		wdata = '{value: sym_value, name: name_ref};
		unique case (state_q)
			ST_IDLE: begin
				we = accept && (kind == KIND_LOAD) && keep && !full;
			end
			ST_WRM: begin
				we    = 1'b1;
				waddr = m_q;
				wdata = ent_i_q;
			end
			ST_WRI: begin
				we    = 1'b1;
				waddr = i_q;
				wdata = '{value: min_q.value & LOW_BITS_CLEAR, name: min_q.name};
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_s1 <= mem[raddr];
		end
		ridx_s1 <= raddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_s1 <= 1'b0;
		end else begin
			rvld_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{code_type: RST_CODE_TYPE, entry_type: RST_ENTRY_TYPE,
				global_scope: RST_GLOBAL, universal_scope: RST_UNIVERSAL};
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_CODE_TYPE:  cfg_q.code_type       <= cfg_wdata;
				REG_ENTRY_TYPE: cfg_q.entry_type      <= cfg_wdata;
				REG_GLOBAL:     cfg_q.global_scope    <= cfg_wdata[SCOPE_W-1:0];
				REG_UNIVERSAL:  cfg_q.universal_scope <= cfg_wdata[SCOPE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= lookup_addr;
			name_q <= '0;
			off_q  <= '0;
		end
		if (state_q == ST_SCAN && rvld_s1) begin
			if (ridx_s1 == i_q) begin
				min_q   <= rdata_s1;
				ent_i_q <= rdata_s1;
				m_q     <= ridx_s1;
			end else if (rdata_s1.value < min_q.value) begin
				min_q <= rdata_s1;
				m_q   <= ridx_s1;
			end
		end
		if (state_q == ST_LOOK && rvld_s1) begin
			if (lk_found) begin
				name_q <= prev_q.name;
				off_q  <= addr_q - prev_q.value;
			end else begin
				prev_q <= rdata_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			ptr_q    <= '0;
			i_q      <= '0;
			done_q   <= 1'b0;
			status_q <= STATUS_OK;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						status_q <= STATUS_OK;
						ptr_q    <= '0;
						i_q      <= '0;
						unique case (kind)
							KIND_LOAD: begin
								done_q <= 1'b1;
								if (!keep) begin
									status_q <= STATUS_DROPPED;
								end else if (full) begin
									status_q <= STATUS_FULL;
								end else begin
									cnt_q <= cnt_q + 1'b1;
								end
							end
							KIND_SORT: begin
								if (cnt_q == '0) begin
									done_q <= 1'b1;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							KIND_LOOKUP: begin
								if (cnt_q == '0) begin
									done_q   <= 1'b1;
									status_q <= STATUS_NOTFOUND;
								end else begin
									state_q <= ST_LOOK;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						ptr_q <= ptr_q + 1'b1;
					end
					if (rvld_s1 && last) begin
						state_q <= ST_WRM;
					end
				end
				ST_WRM: begin
					state_q <= ST_WRI;
				end
				ST_WRI: begin
					if (i_next == cnt_q) begin
						state_q  <= ST_IDLE;
						done_q   <= 1'b1;
						status_q <= STATUS_OK;
					end else begin
						i_q     <= i_q + 1'b1;
						ptr_q   <= i_next;
						state_q <= ST_SCAN;
					end
				end
				ST_LOOK: begin
					if (rd_en) begin
						ptr_q <= ptr_q + 1'b1;
					end
					if (rvld_s1 && (lk_found || lk_miss)) begin
						state_q  <= ST_IDLE;
						done_q   <= 1'b1;
						status_q <= lk_found ? STATUS_OK : STATUS_NOTFOUND;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign cnt_ext        = (CNT_W + KEPT_W)'(cnt_q);
	assign kept_count     = cnt_ext[KEPT_W-1:0];
	assign done           = done_q;
	assign status         = status_q;
	assign found_name_ref = name_q;
	assign found_offset   = off_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_SYMBOLS))
		else $error("Symbol count exceeds the table depth.");

	a_count_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cnt_q) |-> $past(accept && (kind == KIND_LOAD)))
		else $error("Symbol count changed without an accepted load request.");

	a_load_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (kind == KIND_LOAD) |=> done_q && !busy)
		else $error("Load request did not finish in one cycle.");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (status_q != STATUS_OK) |-> (name_q == '0) && (off_q == '0))
		else $error("Result without a hit carries a nonzero name or offset.");

endmodule
